@@ rtl/core/yba_pkg.sv @@
// ----------------------------------------------------------------------------
// yba_pkg
// Shared types and BT.601 integer coefficients for the luma brightness
// adjust pipeline.
// ----------------------------------------------------------------------------
package yba_pkg;

    localparam int SUM_W = 18;

    // Forward conversion, RGB to studio-range YUV.
    localparam logic signed [SUM_W-1:0] K_Y_R   = 18'sd66;
    localparam logic signed [SUM_W-1:0] K_Y_G   = 18'sd129;
    localparam logic signed [SUM_W-1:0] K_Y_B   = 18'sd25;
    localparam logic signed [SUM_W-1:0] K_U_R   = -18'sd38;
    localparam logic signed [SUM_W-1:0] K_U_G   = -18'sd74;
    localparam logic signed [SUM_W-1:0] K_U_B   = 18'sd112;
    localparam logic signed [SUM_W-1:0] K_V_R   = 18'sd112;
    localparam logic signed [SUM_W-1:0] K_V_G   = -18'sd94;
    localparam logic signed [SUM_W-1:0] K_V_B   = -18'sd18;
    localparam logic signed [SUM_W-1:0] K_ROUND = 18'sd128;

    // Inverse conversion, YUV back to RGB.
    localparam logic signed [SUM_W-1:0] K_C     = 18'sd298;
    localparam logic signed [SUM_W-1:0] K_R_E   = 18'sd409;
    localparam logic signed [SUM_W-1:0] K_G_D   = -18'sd100;
    localparam logic signed [SUM_W-1:0] K_G_E   = -18'sd208;
    localparam logic signed [SUM_W-1:0] K_B_D   = 18'sd516;

    // Luma limits.
    localparam logic [7:0]         Y_BASE    = 8'd16;
    localparam logic signed [10:0] Y_ADJ_MIN = 11'sd16;
    localparam logic signed [10:0] Y_ADJ_MAX = 11'sd235;
    localparam logic [7:0]         C_MAX     = 8'd219;

    typedef struct packed {
        logic [15:0]        y_sum;
        logic signed [15:0] u_sum;
        logic signed [15:0] v_sum;
    } t_yuv_sum;

    typedef struct packed {
        logic [7:0]        c;
        logic signed [7:0] d;
        logic signed [7:0] e;
    } t_cde;

    typedef struct packed {
        logic signed [SUM_W-1:0] r_sum;
        logic signed [SUM_W-1:0] g_sum;
        logic signed [SUM_W-1:0] b_sum;
    } t_rgb_sum;

endpackage

@@ rtl/core/yba_fwd_csc.sv @@
// ----------------------------------------------------------------------------
// yba_fwd_csc
// First stage: weighted sums of R, G and B for Y, U and V, with rounding.
// ----------------------------------------------------------------------------
module yba_fwd_csc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    output logic              o_valid,
    input  logic              i_stall,
    output yba_pkg::t_yuv_sum o_sum
);

    logic                            r_valid;
    yba_pkg::t_yuv_sum               r_sum;
    yba_pkg::t_yuv_sum               n_sum;
    logic                            w_adv;
    logic signed [yba_pkg::SUM_W-1:0] w_r;
    logic signed [yba_pkg::SUM_W-1:0] w_g;
    logic signed [yba_pkg::SUM_W-1:0] w_b;
    logic signed [yba_pkg::SUM_W-1:0] w_y;
    logic signed [yba_pkg::SUM_W-1:0] w_u;
    logic signed [yba_pkg::SUM_W-1:0] w_v;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;
    assign o_sum   = r_sum;

    always_comb begin
        w_r = {10'd0, i_red};
        w_g = {10'd0, i_green};
        w_b = {10'd0, i_blue};
        w_y = yba_pkg::K_Y_R * w_r + yba_pkg::K_Y_G * w_g + yba_pkg::K_Y_B * w_b
            + yba_pkg::K_ROUND;
        w_u = yba_pkg::K_U_R * w_r + yba_pkg::K_U_G * w_g + yba_pkg::K_U_B * w_b
            + yba_pkg::K_ROUND;
        w_v = yba_pkg::K_V_R * w_r + yba_pkg::K_V_G * w_g + yba_pkg::K_V_B * w_b
            + yba_pkg::K_ROUND;
        n_sum.y_sum = w_y[15:0];
        n_sum.u_sum = w_u[15:0];
        n_sum.v_sum = w_v[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_sum <= n_sum;
        end
    end

endmodule

@@ rtl/core/yba_luma_adj.sv @@
// ----------------------------------------------------------------------------
// yba_luma_adj
// Second stage: scales the sums down, adds the brightness offset to luma,
// clamps it to the studio range and centers it for the inverse.
// ----------------------------------------------------------------------------
module yba_luma_adj (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  yba_pkg::t_yuv_sum i_sum,
    input  logic [8:0]        i_luma_offset,
    output logic              o_valid,
    input  logic              i_stall,
    output yba_pkg::t_cde     o_cde
);

    logic                r_valid;
    yba_pkg::t_cde       r_cde;
    yba_pkg::t_cde       n_cde;
    logic                w_adv;
    logic [7:0]          w_y;
    logic signed [10:0]  w_y_adj;
    logic signed [10:0]  w_c_full;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;
    assign o_cde   = r_cde;

    always_comb begin
        // The luma sum is never negative, so its upper byte is the floor shift.
        w_y      = i_sum.y_sum[15:8] + yba_pkg::Y_BASE;
        w_y_adj  = {3'b000, w_y} + {{2{i_luma_offset[8]}}, i_luma_offset};
        w_c_full = w_y_adj - yba_pkg::Y_ADJ_MIN;
        if (w_y_adj < yba_pkg::Y_ADJ_MIN) begin
            n_cde.c = 8'd0;
        end else if (w_y_adj > yba_pkg::Y_ADJ_MAX) begin
            n_cde.c = yba_pkg::C_MAX;
        end else begin
            n_cde.c = w_c_full[7:0];
        end
        // The upper byte of a signed sum is its arithmetic shift by eight.
        n_cde.d = i_sum.u_sum[15:8];
        n_cde.e = i_sum.v_sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_cde <= n_cde;
        end
    end

endmodule

@@ rtl/core/yba_inv_csc.sv @@
// ----------------------------------------------------------------------------
// yba_inv_csc
// Third stage: weighted sums of C, D and E for R, G and B, with rounding.
// ----------------------------------------------------------------------------
module yba_inv_csc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  yba_pkg::t_cde     i_cde,
    output logic              o_valid,
    input  logic              i_stall,
    output yba_pkg::t_rgb_sum o_sum
);

    logic                             r_valid;
    yba_pkg::t_rgb_sum                r_sum;
    yba_pkg::t_rgb_sum                n_sum;
    logic                             w_adv;
    logic signed [yba_pkg::SUM_W-1:0] w_c;
    logic signed [yba_pkg::SUM_W-1:0] w_d;
    logic signed [yba_pkg::SUM_W-1:0] w_e;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;
    assign o_sum   = r_sum;

    always_comb begin
        w_c = {10'd0, i_cde.c};
        w_d = {{10{i_cde.d[7]}}, i_cde.d};
        w_e = {{10{i_cde.e[7]}}, i_cde.e};
        n_sum.r_sum = yba_pkg::K_C * w_c + yba_pkg::K_R_E * w_e + yba_pkg::K_ROUND;
        n_sum.g_sum = yba_pkg::K_C * w_c + yba_pkg::K_G_D * w_d + yba_pkg::K_G_E * w_e
                    + yba_pkg::K_ROUND;
        n_sum.b_sum = yba_pkg::K_C * w_c + yba_pkg::K_B_D * w_d + yba_pkg::K_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_sum <= n_sum;
        end
    end

endmodule

@@ rtl/core/yba_clamp_out.sv @@
// ----------------------------------------------------------------------------
// yba_clamp_out
// Last stage: scales the RGB sums down, clamps each channel to 0..255 and
// holds the output beat.
// ----------------------------------------------------------------------------
module yba_clamp_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  yba_pkg::t_rgb_sum i_sum,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue
);

    logic       r_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       w_adv;

    // Takes the floor shift of a sum (its upper ten bits) and clamps it.
    function automatic logic [7:0] clamp_u8(input logic signed [yba_pkg::SUM_W-1:0] sum);
        logic signed [9:0] shifted;
        shifted = sum[yba_pkg::SUM_W-1:8];
        if (shifted[9]) begin
            return 8'd0;
        end else if (shifted[8]) begin
            return 8'd255;
        end else begin
            return shifted[7:0];
        end
    endfunction

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_red   <= clamp_u8(i_sum.r_sum);
            r_green <= clamp_u8(i_sum.g_sum);
            r_blue  <= clamp_u8(i_sum.b_sum);
        end
    end

endmodule

@@ rtl/core/yuv_brightness_adjust_top.sv @@
// Throughput: one pixel per cycle while i_stall is low. An accepted input
// beat passes four register stages to its output; each holds one beat.
// A stage takes a new beat whenever it is empty or its beat moves on.
// Reset (synchronous, active low) empties all stages and sets the offset to 0.
// ----------------------------------------------------------------------------
// yuv_brightness_adjust_top
// RGB pixel brightness adjust in the BT.601 luma domain with clamping.
// ----------------------------------------------------------------------------
module yuv_brightness_adjust_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [8:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_red,
    input  logic [7:0] i_in_green,
    input  logic [7:0] i_in_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue
);

    logic [8:0]        r_luma_offset;
    logic              w_s1_valid;
    logic              w_s1_stall;
    yba_pkg::t_yuv_sum w_s1_sum;
    logic              w_s2_valid;
    logic              w_s2_stall;
    yba_pkg::t_cde     w_s2_cde;
    logic              w_s3_valid;
    logic              w_s3_stall;
    yba_pkg::t_rgb_sum w_s3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_offset <= 9'd0;
        end else if (i_cfg_wr_en) begin
            r_luma_offset <= i_cfg_wr_data;
        end
    end

    yba_fwd_csc u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_in_red),
        .i_green (i_in_green),
        .i_blue  (i_in_blue),
        .o_valid (w_s1_valid),
        .i_stall (w_s1_stall),
        .o_sum   (w_s1_sum)
    );

    yba_luma_adj u_luma (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s1_valid),
        .o_stall       (w_s1_stall),
        .i_sum         (w_s1_sum),
        .i_luma_offset (r_luma_offset),
        .o_valid       (w_s2_valid),
        .i_stall       (w_s2_stall),
        .o_cde         (w_s2_cde)
    );

    yba_inv_csc u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_stall (w_s2_stall),
        .i_cde   (w_s2_cde),
        .o_valid (w_s3_valid),
        .i_stall (w_s3_stall),
        .o_sum   (w_s3_sum)
    );

    yba_clamp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s3_valid),
        .o_stall (w_s3_stall),
        .i_sum   (w_s3_sum),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue)
    );

endmodule

@@ rtl/core/yba_checker.sv @@
// ----------------------------------------------------------------------------
// yba_checker
// Port-level checks on the brightness adjust pipeline, bound to the top.
// ----------------------------------------------------------------------------
module yba_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue
);

    // A stalled output beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue))
        else $error("output beat changed while stalled");

    // The input side only stalls when the whole pipeline is full and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // An accepted beat reaches the output when nothing stalls on the way.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted beat did not arrive after four cycles");

endmodule

bind yuv_brightness_adjust_top yba_checker u_yba_checker (.*);
